/* rtl/percent_decode_utf8_check_core_assert.svh */
// Assertion macros for the checker module of the percent-decode core.
// No dependencies; included by the checker file.
`ifndef PERCENT_DECODE_UTF8_CHECK_CORE_ASSERT_SVH
`define PERCENT_DECODE_UTF8_CHECK_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PDU8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PDU8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pdu8_pkg.sv */
// Shared types, constants and helpers for the percent-decode / UTF-8 check core.
// No dependencies.
package pdu8_pkg;

    localparam int NAME_BUFFER_BYTES_DEF = 64;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;
    localparam int COUNT_W     = 6;
    localparam int STATUS_W    = 3;
    localparam int CP_W        = 21;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IN_LONG  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ESC  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_LONG = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_UTF8 = 3'd4;

    // first escape/length error, kept in two bits
    localparam logic [1:0] DERR_NONE     = 2'd0;
    localparam logic [1:0] DERR_BAD_ESC  = 2'd2;
    localparam logic [1:0] DERR_OUT_LONG = 2'd3;

    // escape sequencer codes
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7f;
    localparam logic [7:0] LEAD2_LO   = 8'hc2;
    localparam logic [7:0] LEAD2_HI   = 8'hdf;
    localparam logic [7:0] LEAD4_LO   = 8'hf0;
    localparam logic [7:0] LEAD4_HI   = 8'hf4;

    localparam logic [CP_W-1:0] CP_MIN3 = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4 = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00dfff;
    localparam logic [CP_W-1:0] CP_MAX  = 21'h10ffff;

    typedef struct packed {
        logic                byte_valid;
        logic [7:0]          decoded_byte;
        logic                done;
        logic                accepted;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  decoded_count;
    } res_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        r = 5'd0;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            r = {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

/* rtl/percent_decode_utf8_check_core.sv */
// Percent-decode with strict UTF-8 validation, top level.
// Depends on pdu8_pkg and pdu8_step.
//
//  channel | dir | tdata                                  | tlast    | tuser
//  s_*     | in  | [7:0] in_byte                          | in_last  | -
//  m_*     | out | [7:0] byte [8] accepted [11:9] status  | done_res | byte_valid
//          |     | [17:12] decoded_count, [23:18] zero    |          |
//
// One byte per cycle while s_tready is high; each result is registered in the output buffer.
// The decode step is combinational; a two-entry output buffer
// (output register plus skid) keeps input flowing while one result waits.
// s_tready drops only when both entries hold results.
// rst_n clears decode state and the output buffer at once; no clearing pass.
module percent_decode_utf8_check_core
    import pdu8_pkg::*;
#(
    parameter int NAME_BUFFER_BYTES = NAME_BUFFER_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] in_byte
    input  logic                   s_tlast,   // in_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // byte, accepted, status, decoded_count
    output logic                   m_tlast,   // done_res
    output logic                   m_tuser    // byte_valid
);

    res_t res;
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic acc;
    logic take;

    assign s_tready = !skid_valid_reg;
    assign acc      = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;

    pdu8_step #(
        .NAME_BUFFER_BYTES(NAME_BUFFER_BYTES)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (acc),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .res     (res)
    );

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = acc;
            end
        end else if (acc) begin
            if (!out_valid_reg) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.done;
    assign m_tuser  = out_reg.byte_valid;
    assign m_tdata  = {{(TDATA_OUT_W - COUNT_W - STATUS_W - 9){1'b0}},
                       out_reg.decoded_count, out_reg.status,
                       out_reg.accepted, out_reg.decoded_byte};

endmodule

/* rtl/pdu8_step.sv */
// Running decode state: escape sequencer, length counters and UTF-8 checker.
// Produces the result for the presented byte; state advances on adv.
// Depends on pdu8_pkg.
module pdu8_step
    import pdu8_pkg::*;
#(
    parameter int NAME_BUFFER_BYTES = NAME_BUFFER_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output res_t       res
);

    localparam int IN_LIMIT = 3 * (NAME_BUFFER_BYTES - 1);
    localparam int ICW      = $clog2(IN_LIMIT + 2);
    localparam int OCW      = $clog2(NAME_BUFFER_BYTES);
    localparam logic [ICW-1:0] IN_LIM  = ICW'(IN_LIMIT);
    localparam logic [OCW-1:0] OUT_LIM = OCW'(NAME_BUFFER_BYTES - 1);

    logic [1:0]      esc_reg,   esc_next;
    logic [3:0]      hi_reg,    hi_next;
    logic [ICW-1:0]  in_cnt_reg, in_cnt_next;
    logic [OCW-1:0]  out_cnt_reg, out_cnt_next;
    logic [1:0]      cont_reg,  cont_next;
    logic [1:0]      seq_reg,   seq_next;
    logic [CP_W-1:0] cp_reg,    cp_next;
    logic [1:0]      derr_reg,  derr_next;
    logic            uerr_reg,  uerr_next;

    logic            formed;
    logic [7:0]      value;
    logic            emit;
    logic [4:0]      hx;
    logic [CP_W-1:0] cp_shift;
    logic [1:0]      cont_dec;
    logic [STATUS_W-1:0] status;
    logic [OCW+COUNT_W-1:0] count_ext;

    always_comb
    begin
        esc_next     = esc_reg;
        hi_next      = hi_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        cont_next    = cont_reg;
        seq_next     = seq_reg;
        cp_next      = cp_reg;
        derr_next    = derr_reg;
        uerr_next    = uerr_reg;
        formed       = 1'b0;
        value        = 8'd0;
        emit         = 1'b0;
        status       = ST_OK;
        hx           = hex_val(in_byte);
        cp_shift     = {cp_reg[CP_W-7:0], in_byte[5:0]};
        cont_dec     = cont_reg - 2'd1;

        if (in_cnt_reg <= IN_LIM)
            in_cnt_next = in_cnt_reg + ICW'(1);

        // escape sequencer
        if (esc_reg == ESC_IDLE) begin
            if (in_byte == CH_PERCENT)
                esc_next = ESC_HIGH;
            else begin
                formed = 1'b1;
                value  = in_byte;
            end
        end else if (!hx[4]) begin
            if (derr_next == DERR_NONE)
                derr_next = DERR_BAD_ESC;
            esc_next = ESC_IDLE;
        end else if (esc_reg == ESC_HIGH) begin
            hi_next  = hx[3:0];
            esc_next = ESC_LOW;
        end else begin
            formed   = 1'b1;
            value    = {hi_reg, hx[3:0]};
            esc_next = ESC_IDLE;
        end

        if (formed) begin
            if (out_cnt_reg >= OUT_LIM) begin
                if (derr_next == DERR_NONE)
                    derr_next = DERR_OUT_LONG;
            end else begin
                out_cnt_next = out_cnt_reg + OCW'(1);
                emit         = 1'b1;
                // UTF-8 checker
                if (cont_reg == 2'd0) begin
                    if (!value[7]) begin
                        if (value < CH_SPACE || value == CH_DEL)
                            uerr_next = 1'b1;
                    end else if (value >= LEAD2_LO && value <= LEAD2_HI) begin
                        cp_next   = {16'd0, value[4:0]};
                        seq_next  = 2'd1;
                        cont_next = 2'd1;
                    end else if (value[7:4] == 4'he) begin
                        cp_next   = {17'd0, value[3:0]};
                        seq_next  = 2'd2;
                        cont_next = 2'd2;
                    end else if (value >= LEAD4_LO && value <= LEAD4_HI) begin
                        cp_next   = {18'd0, value[2:0]};
                        seq_next  = 2'd3;
                        cont_next = 2'd3;
                    end else
                        uerr_next = 1'b1;
                end else if (value[7:6] != 2'b10) begin
                    uerr_next = 1'b1;
                    cont_next = 2'd0;
                end else begin
                    cp_shift  = {cp_reg[CP_W-7:0], value[5:0]};
                    cp_next   = cp_shift;
                    cont_next = cont_dec;
                    if (cont_dec == 2'd0) begin
                        if ((seq_reg == 2'd2 && cp_shift < CP_MIN3) ||
                            (seq_reg == 2'd3 && cp_shift < CP_MIN4) ||
                            (cp_shift >= SURR_LO && cp_shift <= SURR_HI) ||
                            cp_shift > CP_MAX)
                            uerr_next = 1'b1;
                    end
                end
            end
        end

        if (in_last) begin
            if (esc_next != ESC_IDLE && derr_next == DERR_NONE)
                derr_next = DERR_BAD_ESC;
            if (in_cnt_next > IN_LIM)
                status = ST_IN_LONG;
            else if (derr_next != DERR_NONE)
                status = {1'b0, derr_next};
            else if (uerr_next || cont_next != 2'd0)
                status = ST_BAD_UTF8;
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, out_cnt_next};

    always_comb
    begin
        res.byte_valid    = emit;
        res.decoded_byte  = emit ? value : 8'd0;
        res.done          = in_last;
        res.accepted      = in_last && (status == ST_OK);
        res.status        = status;
        res.decoded_count = count_ext[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            esc_reg     <= ESC_IDLE;
            hi_reg      <= 4'd0;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            cont_reg    <= 2'd0;
            seq_reg     <= 2'd0;
            cp_reg      <= '0;
            derr_reg    <= DERR_NONE;
            uerr_reg    <= 1'b0;
        end else if (adv) begin
            if (in_last) begin
                // name finished: start the next one clean
                esc_reg     <= ESC_IDLE;
                hi_reg      <= 4'd0;
                in_cnt_reg  <= '0;
                out_cnt_reg <= '0;
                cont_reg    <= 2'd0;
                seq_reg     <= 2'd0;
                cp_reg      <= '0;
                derr_reg    <= DERR_NONE;
                uerr_reg    <= 1'b0;
            end else begin
                esc_reg     <= esc_next;
                hi_reg      <= hi_next;
                in_cnt_reg  <= in_cnt_next;
                out_cnt_reg <= out_cnt_next;
                cont_reg    <= cont_next;
                seq_reg     <= seq_next;
                cp_reg      <= cp_next;
                derr_reg    <= derr_next;
                uerr_reg    <= uerr_next;
            end
        end
    end

endmodule

/* rtl/pdu8_checker.sv */
// Port-level checks on the percent-decode core's result stream.
// Depends on pdu8_pkg and percent_decode_utf8_check_core_assert.svh; bound to the top.
`include "percent_decode_utf8_check_core_assert.svh"

module pdu8_checker
    import pdu8_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata,
    input logic                   m_tlast,
    input logic                   m_tuser
);

    `PDU8_ASSERT_NOW(a_no_byte_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0, "byte field not zero without a decoded byte")

    `PDU8_ASSERT_NOW(a_mid_quiet, clk, rst_n, m_tvalid && !m_tlast, m_tdata[11:9] == ST_OK && !m_tdata[8], "status or accepted set before the last transfer")

    `PDU8_ASSERT_NOW(a_accept_ok, clk, rst_n, m_tvalid && m_tlast, m_tdata[8] == (m_tdata[11:9] == ST_OK), "accepted disagrees with status")

    `PDU8_ASSERT_NOW(a_status_range, clk, rst_n, m_tvalid, m_tdata[11:9] <= ST_BAD_UTF8, "status code out of range")

    `PDU8_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind percent_decode_utf8_check_core pdu8_checker u_pdu8_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
